@@ rtl/core/plpc_pkg.sv @@
// Shared constants and types for the polygon lattice point counter.
`timescale 1ns / 1ps

package plpc_pkg;

    // Port widths of the vertex and result fields.
    localparam int VERTEX_W   = 30;
    localparam int INTERIOR_W = 61;
    localparam int BOUNDARY_W = 63;

    // Coordinate bits actually used; each coordinate is sign-extended from here.
    localparam int COORD_BITS = 30;

    // Derived widths.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int K_W    = $clog2(DIFF_W);
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int ACC_W  = 64;

    // Edge queue between the vertex front end and the edge engine.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One queued request: the vertex with the context needed to form its edges.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] prev_x;
        logic signed [COORD_BITS-1:0] prev_y;
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic                         has_prev;
        logic                         last;
    } t_edge_job;

endpackage

@@ rtl/core/plpc_front.sv @@
// Vertex front end: tracks first and previous vertex and queues edge work.
`timescale 1ns / 1ps

module plpc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vertex_valid,
    input  logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_x,
    input  logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_y,
    input  logic                                i_last_vertex,
    input  logic                                i_q_full,
    output logic                                o_vertex_stall,
    output logic                                o_push,
    output plpc_pkg::t_edge_job                 o_job
);

    logic signed [plpc_pkg::COORD_BITS-1:0] r_first_x;
    logic signed [plpc_pkg::COORD_BITS-1:0] r_first_y;
    logic signed [plpc_pkg::COORD_BITS-1:0] r_prev_x;
    logic signed [plpc_pkg::COORD_BITS-1:0] r_prev_y;
    logic                                   r_have_vertex;

    logic signed [plpc_pkg::COORD_BITS-1:0] w_x;
    logic signed [plpc_pkg::COORD_BITS-1:0] w_y;

    assign w_x = i_vertex_x[plpc_pkg::COORD_BITS-1:0];
    assign w_y = i_vertex_y[plpc_pkg::COORD_BITS-1:0];

    assign o_vertex_stall = i_q_full;
    assign o_push         = i_vertex_valid && !i_q_full;

    always_comb begin
        o_job.first_x  = r_have_vertex ? r_first_x : w_x;
        o_job.first_y  = r_have_vertex ? r_first_y : w_y;
        o_job.prev_x   = r_prev_x;
        o_job.prev_y   = r_prev_y;
        o_job.cur_x    = w_x;
        o_job.cur_y    = w_y;
        o_job.has_prev = r_have_vertex;
        o_job.last     = i_last_vertex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x     <= '0;
            r_first_y     <= '0;
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_have_vertex <= 1'b0;
        end else if (o_push) begin
            if (!r_have_vertex) begin
                r_first_x <= w_x;
                r_first_y <= w_y;
            end
            r_prev_x      <= w_x;
            r_prev_y      <= w_y;
            // The last vertex closes the polygon, so the next one starts a new one.
            r_have_vertex <= !i_last_vertex;
        end
    end

endmodule

@@ rtl/core/plpc_queue.sv @@
// Short FIFO of edge requests between the front end and the edge engine.
`timescale 1ns / 1ps

module plpc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  plpc_pkg::t_edge_job i_job,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output plpc_pkg::t_edge_job o_job
);

    plpc_pkg::t_edge_job              r_mem [plpc_pkg::QDEPTH];
    logic [plpc_pkg::QPTR_W-1:0]      r_wr;
    logic [plpc_pkg::QPTR_W-1:0]      r_rd;
    logic [plpc_pkg::QCNT_W-1:0]      r_count;
    logic                             w_do_push;
    logic                             w_do_pop;

    assign o_full    = (r_count == plpc_pkg::QCNT_W'(plpc_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == plpc_pkg::QPTR_W'(plpc_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == plpc_pkg::QPTR_W'(plpc_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/plpc_gcd.sv @@
// Iterative binary GCD unit, one shift or subtract step per cycle.
`timescale 1ns / 1ps

module plpc_gcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plpc_pkg::DIFF_W-1:0]   i_a,
    input  logic [plpc_pkg::DIFF_W-1:0]   i_b,
    output logic                          o_busy,
    output logic [plpc_pkg::DIFF_W-1:0]   o_gcd
);

    logic [plpc_pkg::DIFF_W-1:0] r_a;
    logic [plpc_pkg::DIFF_W-1:0] r_b;
    logic [plpc_pkg::K_W-1:0]    r_k;
    logic [plpc_pkg::DIFF_W-1:0] r_gcd;
    logic                        r_busy;

    assign o_busy = r_busy;
    assign o_gcd  = r_gcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_k    <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // Common factors of two are counted in r_k and restored at the end.
            if (r_a == '0) begin
                r_gcd  <= r_b << r_k;
                r_busy <= 1'b0;
            end else if (r_b == '0) begin
                r_gcd  <= r_a << r_k;
                r_busy <= 1'b0;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= (r_a - r_b) >> 1;
            end else begin
                r_b <= (r_b - r_a) >> 1;
            end
        end
    end

endmodule

@@ rtl/core/plpc_back.sv @@
// Edge engine: accumulates doubled area and boundary count, then forms the result.
`timescale 1ns / 1ps

module plpc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  plpc_pkg::t_edge_job                 i_job,
    output logic                                o_pop,
    output logic                                o_result_valid,
    input  logic                                i_result_stall,
    output logic [plpc_pkg::INTERIOR_W-1:0]     o_interior_points,
    output logic [plpc_pkg::BOUNDARY_W-1:0]     o_perimeter_points
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_LOAD = 3'd1;
    localparam logic [2:0] B_MUL2 = 3'd2;
    localparam logic [2:0] B_SUB  = 3'd3;
    localparam logic [2:0] B_GCD  = 3'd4;
    localparam logic [2:0] B_ABS  = 3'd5;
    localparam logic [2:0] B_DIFF = 3'd6;
    localparam logic [2:0] B_OUT  = 3'd7;

    localparam int CW = plpc_pkg::COORD_BITS;

    logic [2:0]                          r_state;
    logic                                r_last;
    logic                                r_closing;
    logic signed [CW-1:0]                r_ax;
    logic signed [CW-1:0]                r_ay;
    logic signed [CW-1:0]                r_bx;
    logic signed [CW-1:0]                r_by;
    logic signed [CW-1:0]                r_first_x;
    logic signed [CW-1:0]                r_first_y;
    logic signed [plpc_pkg::PROD_W-1:0]  r_prod;
    logic [plpc_pkg::ACC_W-1:0]          r_area;
    logic [plpc_pkg::ACC_W-1:0]          r_edge;
    logic                                r_out_valid;
    logic [plpc_pkg::INTERIOR_W-1:0]     r_interior;
    logic [plpc_pkg::BOUNDARY_W-1:0]     r_boundary;

    logic signed [CW-1:0]                w_mul_a;
    logic signed [CW-1:0]                w_mul_b;
    logic signed [plpc_pkg::PROD_W-1:0]  w_prod;
    logic [plpc_pkg::ACC_W-1:0]          w_prod_ext;
    logic signed [plpc_pkg::DIFF_W-1:0]  w_dx;
    logic signed [plpc_pkg::DIFF_W-1:0]  w_dy;
    logic [plpc_pkg::DIFF_W-1:0]         w_abs_dx;
    logic [plpc_pkg::DIFF_W-1:0]         w_abs_dy;
    logic                                w_gcd_start;
    logic                                w_gcd_busy;
    logic [plpc_pkg::DIFF_W-1:0]         w_gcd;
    logic [plpc_pkg::ACC_W-1:0]          w_half;
    logic                                w_out_free;

    assign o_pop              = (r_state == B_IDLE) && !i_q_empty;
    assign o_result_valid     = r_out_valid;
    assign o_interior_points  = r_interior;
    assign o_perimeter_points = r_boundary;
    assign w_out_free         = !r_out_valid || !i_result_stall;

    // One shared multiplier: ax*by in the load cycle, bx*ay in the next.
    assign w_mul_a    = (r_state == B_LOAD) ? r_ax : r_bx;
    assign w_mul_b    = (r_state == B_LOAD) ? r_by : r_ay;
    assign w_prod     = plpc_pkg::PROD_W'(w_mul_a) * plpc_pkg::PROD_W'(w_mul_b);
    assign w_prod_ext = {{(plpc_pkg::ACC_W - plpc_pkg::PROD_W){r_prod[plpc_pkg::PROD_W-1]}},
                         r_prod};

    assign w_dx     = {r_bx[CW-1], r_bx} - {r_ax[CW-1], r_ax};
    assign w_dy     = {r_by[CW-1], r_by} - {r_ay[CW-1], r_ay};
    assign w_abs_dx = w_dx[plpc_pkg::DIFF_W-1] ? -w_dx : w_dx;
    assign w_abs_dy = w_dy[plpc_pkg::DIFF_W-1] ? -w_dy : w_dy;

    assign w_gcd_start = (r_state == B_LOAD);
    assign w_half      = {r_area[plpc_pkg::ACC_W-1], r_area[plpc_pkg::ACC_W-1:1]};

    plpc_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (w_abs_dx),
        .i_b     (w_abs_dy),
        .o_busy  (w_gcd_busy),
        .o_gcd   (w_gcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_area      <= '0;
            r_edge      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == B_OUT) && w_out_free)
                           || (r_out_valid && i_result_stall);
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_last    <= i_job.last;
                        r_first_x <= i_job.first_x;
                        r_first_y <= i_job.first_y;
                        if (i_job.has_prev) begin
                            r_ax      <= i_job.prev_x;
                            r_ay      <= i_job.prev_y;
                            r_bx      <= i_job.cur_x;
                            r_by      <= i_job.cur_y;
                            r_closing <= 1'b0;
                            r_state   <= B_LOAD;
                        end else if (i_job.last) begin
                            // A lone vertex closes onto itself: a zero-length edge.
                            r_ax      <= i_job.cur_x;
                            r_ay      <= i_job.cur_y;
                            r_bx      <= i_job.first_x;
                            r_by      <= i_job.first_y;
                            r_closing <= 1'b1;
                            r_state   <= B_LOAD;
                        end
                    end
                end
                B_LOAD: begin
                    r_prod  <= w_prod;
                    r_state <= B_MUL2;
                end
                B_MUL2: begin
                    r_area  <= r_area + w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= B_SUB;
                end
                B_SUB: begin
                    r_area  <= r_area - w_prod_ext;
                    r_state <= B_GCD;
                end
                B_GCD: begin
                    if (!w_gcd_busy) begin
                        r_edge <= r_edge
                                  + {{(plpc_pkg::ACC_W - plpc_pkg::DIFF_W){1'b0}}, w_gcd};
                        if (r_last && !r_closing) begin
                            r_ax      <= r_bx;
                            r_ay      <= r_by;
                            r_bx      <= r_first_x;
                            r_by      <= r_first_y;
                            r_closing <= 1'b1;
                            r_state   <= B_LOAD;
                        end else if (r_last) begin
                            r_state <= B_ABS;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_ABS: begin
                    if (r_area[plpc_pkg::ACC_W-1]) begin
                        r_area <= '0 - r_area;
                    end
                    r_state <= B_DIFF;
                end
                B_DIFF: begin
                    r_area  <= r_area - r_edge;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_interior  <= plpc_pkg::INTERIOR_W'(w_half + 1'b1);
                        r_boundary  <= r_edge[plpc_pkg::BOUNDARY_W-1:0];
                        r_area      <= '0;
                        r_edge      <= '0;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/polygon_lattice_point_counter_core.sv @@
// Top level of the polygon lattice point counter.
`timescale 1ns / 1ps

// Vertices of a lattice polygon arrive one per request, the last one flagged; one
// result with the interior and boundary point counts (Pick's theorem) follows the
// last vertex. A vertex enters a two-entry queue; the edge engine takes it in idle
// and works its edge through the load, multiply, subtract and GCD states; the GCD
// state waits on a binary GCD of the edge's absolute coordinate differences, one
// step per cycle. The last vertex of a polygon adds the closing edge, which goes
// from the GCD state straight back to load without the queue; then the result is
// formed in the abs, diff and out states and waits in the output register as long
// as the result is stalled. The GCD iteration sets the rate.

module polygon_lattice_point_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vertex_valid,
    output logic                                o_vertex_stall,
    input  logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_x,
    input  logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_y,
    input  logic                                i_last_vertex,
    output logic                                o_result_valid,
    input  logic                                i_result_stall,
    output logic [plpc_pkg::INTERIOR_W-1:0]     o_interior_points,
    output logic [plpc_pkg::BOUNDARY_W-1:0]     o_perimeter_points
);

    plpc_pkg::t_edge_job w_push_job;
    plpc_pkg::t_edge_job w_head_job;
    logic                w_push;
    logic                w_pop;
    logic                w_q_full;
    logic                w_q_empty;

    plpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_valid (i_vertex_valid),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_last_vertex  (i_last_vertex),
        .i_q_full       (w_q_full),
        .o_vertex_stall (o_vertex_stall),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    plpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_job   (w_head_job)
    );

    plpc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (w_q_empty),
        .i_job              (w_head_job),
        .o_pop              (w_pop),
        .o_result_valid     (o_result_valid),
        .i_result_stall     (i_result_stall),
        .o_interior_points  (o_interior_points),
        .o_perimeter_points (o_perimeter_points)
    );

endmodule

@@ rtl/core/plpc_checker.sv @@
// Port-level checks for the polygon lattice point counter, bound to the top level.
`timescale 1ns / 1ps

module plpc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_vertex_valid,
    input logic                                o_vertex_stall,
    input logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_x,
    input logic [plpc_pkg::VERTEX_W-1:0]       i_vertex_y,
    input logic                                i_last_vertex,
    input logic                                o_result_valid,
    input logic                                i_result_stall,
    input logic [plpc_pkg::INTERIOR_W-1:0]     o_interior_points,
    input logic [plpc_pkg::BOUNDARY_W-1:0]     o_perimeter_points
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_result_valid && i_result_stall) |-> o_result_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_result_valid && i_result_stall)
        |-> $stable(o_interior_points) && $stable(o_perimeter_points))
        else $error("result payload changed while stalled");

    // Reset empties the output register and the edge queue.
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result offered right after reset");

    a_reset_no_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vertex_stall)
        else $error("vertex input stalled right after reset");

endmodule

bind polygon_lattice_point_counter_core plpc_checker u_plpc_checker (.*);

@@ tb/plpc_count_checker.sv @@
// Checker that predicts and compares the lattice point counts of each polygon.
`timescale 1ns / 1ps

module plpc_count_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vertex_valid,
    input  logic                            i_vertex_stall,
    input  logic [plpc_pkg::VERTEX_W-1:0]   i_vertex_x,
    input  logic [plpc_pkg::VERTEX_W-1:0]   i_vertex_y,
    input  logic                            i_last_vertex,
    input  logic                            i_result_valid,
    input  logic                            i_result_stall,
    input  logic [plpc_pkg::INTERIOR_W-1:0] i_interior_points,
    input  logic [plpc_pkg::BOUNDARY_W-1:0] i_perimeter_points,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results_checked
);

    typedef struct {
        logic [plpc_pkg::INTERIOR_W-1:0] interior;
        logic [plpc_pkg::BOUNDARY_W-1:0] boundary;
    } t_point_count;

    t_point_count expected_counts[$];

    // Polygon in progress; coordinates are kept sign-extended to 64 bits.
    logic [63:0] first_x, first_y, prev_x, prev_y;
    logic [63:0] area2_acc, boundary_acc;
    logic        in_polygon;

    function automatic logic [63:0] widen_coord(input logic [plpc_pkg::VERTEX_W-1:0] v);
        return {{(64 - plpc_pkg::COORD_BITS){v[plpc_pkg::COORD_BITS-1]}},
                v[plpc_pkg::COORD_BITS-1:0]};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic void clear_polygon();
        first_x      = '0;
        first_y      = '0;
        prev_x       = '0;
        prev_y       = '0;
        area2_acc    = '0;
        boundary_acc = '0;
        in_polygon   = 1'b0;
    endfunction

    // Shoelace term plus the lattice points of one edge, gcd(0,0) being zero.
    function automatic void add_edge_terms(input logic [63:0] ax, input logic [63:0] ay,
                                           input logic [63:0] bx, input logic [63:0] by);
        logic [63:0] a, b, t;
        area2_acc = area2_acc + (ax * by - bx * ay);
        a = mag64(bx - ax);
        b = mag64(by - ay);
        while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
        end
        boundary_acc = boundary_acc + a;
    endfunction

    always @(posedge i_clk) begin : p_check
        t_point_count counts;
        logic [63:0]  cur_x, cur_y, diff;
        if (!i_rst_n) begin
            clear_polygon();
            expected_counts.delete();
            o_fail_count      = 0;
            o_results_checked = 0;
        end else begin
            if (i_result_valid && !i_result_stall) begin
                if (expected_counts.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with no polygon pending: interior %0d, boundary %0d",
                             $time, i_interior_points, i_perimeter_points);
                end else begin
                    counts = expected_counts.pop_front();
                    o_results_checked++;
                    if (i_interior_points !== counts.interior) begin
                        o_fail_count++;
                        $display("%0t: interior_points mismatch: expected %0d, actual %0d",
                                 $time, counts.interior, i_interior_points);
                    end
                    if (i_perimeter_points !== counts.boundary) begin
                        o_fail_count++;
                        $display("%0t: perimeter_points mismatch: expected %0d, actual %0d",
                                 $time, counts.boundary, i_perimeter_points);
                    end
                end
            end
            if (i_vertex_valid && !i_vertex_stall) begin
                cur_x = widen_coord(i_vertex_x);
                cur_y = widen_coord(i_vertex_y);
                if (!in_polygon) begin
                    first_x    = cur_x;
                    first_y    = cur_y;
                    in_polygon = 1'b1;
                end else begin
                    add_edge_terms(prev_x, prev_y, cur_x, cur_y);
                end
                prev_x = cur_x;
                prev_y = cur_y;
                if (i_last_vertex) begin
                    add_edge_terms(cur_x, cur_y, first_x, first_y);
                    // Pick's theorem with an arithmetic halving of the 64-bit difference.
                    diff            = mag64(area2_acc) - boundary_acc;
                    diff            = {diff[63], diff[63:1]} + 64'd1;
                    counts.interior = diff[plpc_pkg::INTERIOR_W-1:0];
                    counts.boundary = boundary_acc[plpc_pkg::BOUNDARY_W-1:0];
                    expected_counts.push_back(counts);
                    clear_polygon();
                end
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

@@ tb/tb_polygon_lattice_point_counter_core.sv @@
// Testbench top: drives polygon vertices and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb_polygon_lattice_point_counter_core;

    localparam int RANDOM_VERTICES = 1850;
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 300;
    localparam int COORD_MAX       = (1 << (plpc_pkg::VERTEX_W - 1)) - 1;
    localparam int COORD_MIN       = -(1 << (plpc_pkg::VERTEX_W - 1));

    typedef enum int {COORD_SMALL, COORD_MID, COORD_FULL, COORD_EDGE} t_coord_range;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_vertex_valid = 1'b0;
    logic [plpc_pkg::VERTEX_W-1:0]   i_vertex_x     = '0;
    logic [plpc_pkg::VERTEX_W-1:0]   i_vertex_y     = '0;
    logic                            i_last_vertex  = 1'b0;
    logic                            i_result_stall = 1'b0;
    logic                            o_vertex_stall;
    logic                            o_result_valid;
    logic [plpc_pkg::INTERIOR_W-1:0] o_interior_points;
    logic [plpc_pkg::BOUNDARY_W-1:0] o_perimeter_points;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int holds_done      = 0;
    int vertices_sent   = 0;
    int polygons_sent   = 0;
    int polygon_len     = 0;
    int longest_polygon = 0;
    int fail_count;
    int pending;
    int results_checked;

    polygon_lattice_point_counter_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vertex_valid     (i_vertex_valid),
        .o_vertex_stall     (o_vertex_stall),
        .i_vertex_x         (i_vertex_x),
        .i_vertex_y         (i_vertex_y),
        .i_last_vertex      (i_last_vertex),
        .o_result_valid     (o_result_valid),
        .i_result_stall     (i_result_stall),
        .o_interior_points  (o_interior_points),
        .o_perimeter_points (o_perimeter_points)
    );

    plpc_count_checker u_count_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vertex_valid     (i_vertex_valid),
        .i_vertex_stall     (o_vertex_stall),
        .i_vertex_x         (i_vertex_x),
        .i_vertex_y         (i_vertex_y),
        .i_last_vertex      (i_last_vertex),
        .i_result_valid     (o_result_valid),
        .i_result_stall     (i_result_stall),
        .i_interior_points  (o_interior_points),
        .i_perimeter_points (o_perimeter_points),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_results_checked  (results_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(12_000_000);
        $display("run timed out with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when the stimulus asks for it.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                i_result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                i_result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_vertex(input int x, input int y, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_vertex_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_vertex_valid <= 1'b1;
        i_vertex_x     <= x[plpc_pkg::VERTEX_W-1:0];
        i_vertex_y     <= y[plpc_pkg::VERTEX_W-1:0];
        i_last_vertex  <= last;
        @(posedge i_clk);
        while (o_vertex_stall) @(posedge i_clk);
        vertices_sent++;
        polygon_len++;
        if (last) begin
            polygons_sent++;
            if (polygon_len > longest_polygon) longest_polygon = polygon_len;
            polygon_len = 0;
        end
    endtask

    // Stop offering vertices until every pending polygon has produced its result.
    task automatic wait_all_counted();
        i_vertex_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic int pick_coord(input t_coord_range span);
        if ($urandom_range(7) == 0) span = COORD_EDGE;
        case (span)
            COORD_SMALL: return int'($urandom_range(32)) - 16;
            COORD_MID:   return int'($urandom_range(8191)) - 4096;
            COORD_FULL:  return int'($urandom());
            default: begin
                case ($urandom_range(3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_polygon();
        int           n;
        int           roll;
        t_coord_range span;
        roll = $urandom_range(99);
        if (roll < 10) begin
            n = 1;
        end else if (roll < 85) begin
            n = $urandom_range(8, 3);
        end else begin
            n = $urandom_range(24, 9);
        end
        span = t_coord_range'($urandom_range(3));
        for (int k = 0; k < n; k++) begin
            send_vertex(pick_coord(span), pick_coord(span), k == n - 1);
        end
    endtask

    initial begin
        int base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A lone vertex, a repeated vertex and a flat segment with more boundary than area.
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(6, -9, 1'b1);

        // Four turns around the full coordinate square plus a thin triangle put the
        // doubled area exactly on the most negative 64-bit value.
        repeat (4) begin
            send_vertex(COORD_MIN, COORD_MIN, 1'b0);
            send_vertex(COORD_MAX, COORD_MIN, 1'b0);
            send_vertex(COORD_MAX, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        end
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN + (1 << 17), COORD_MIN + 1, 1'b0);
        send_vertex(COORD_MIN + 8, COORD_MIN + (1 << 17), 1'b1);

        base = vertices_sent;
        for (int phase = 0; phase < 3; phase++) begin
            wait_all_counted();
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_requests++;
                end
            endcase
            while (vertices_sent < base + (phase + 1) * RANDOM_VERTICES / 3) begin
                send_random_polygon();
            end
        end

        wait_all_counted();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d vertices in %0d polygons (longest %0d), checked %0d results",
                 vertices_sent, polygons_sent, longest_polygon, results_checked);
        $display("across three idling mixes, a long result hold-off and drain pauses");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
